// File: hw/rtl/vgd_pkg.sv
// Shared types, constants and handshake bundles of the voxel grid downsampler.
`timescale 1ns / 1ps

package vgd_pkg;

    localparam int CAPACITY   = 4096;
    localparam int HASH_SLOTS = 8192;
    localparam int MAX_PROBE  = 8;

    localparam int ENT_W     = $clog2(CAPACITY);
    localparam int ENT_CNT_W = $clog2(CAPACITY + 1);
    localparam int SLOT_W    = $clog2(HASH_SLOTS);
    localparam int PROBE_W   = $clog2(MAX_PROBE + 1);

    localparam int COORD_W = 32;
    localparam int INT_W   = 16;
    localparam int INV_W   = 24;
    localparam int KEY_W   = 24;
    localparam int SUM_W   = 56;
    localparam int ISUM_W  = 40;
    localparam int CNT_W   = 24;
    localparam int PROD_W  = COORD_W + INV_W + 1;
    localparam int FRAC_W  = 32;

    localparam int HASH_MUL = 116101;
    localparam logic [SLOT_W-1:0] HASH_MUL_LO = SLOT_W'(HASH_MUL % HASH_SLOTS);

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [INV_W-1:0] INV_RESET = INV_W'(65536);

    localparam int DIV_LANES = 4;
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int S_TDATA_W = 3 * COORD_W + INT_W;
    localparam int M_TDATA_W = 3 * COORD_W + INT_W + CNT_W;

    typedef enum logic [2:0] {
        ST_MERGED  = 3'd0,
        ST_NEW     = 3'd1,
        ST_TFULL   = 3'd2,
        ST_CFULL   = 3'd3,
        ST_DRAINED = 3'd4,
        ST_EMPTY   = 3'd5
    } status_t;

    typedef enum logic {
        FN_ADD   = 1'b0,
        FN_DRAIN = 1'b1
    } func_t;

    typedef struct packed {
        logic             vld;
        logic [ENT_W-1:0] idx;
    } slot_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key_x;
        logic [KEY_W-1:0]  key_y;
        logic [KEY_W-1:0]  key_z;
        logic [SUM_W-1:0]  sum_x;
        logic [SUM_W-1:0]  sum_y;
        logic [SUM_W-1:0]  sum_z;
        logic [ISUM_W-1:0] sum_i;
        logic [CNT_W-1:0]  cnt;
    } entry_t;

    typedef struct packed {
        logic load;
        logic drain_rd;
        logic mul;
        logic hash1;
        logic hash2;
        logic slot_rd;
        logic ent_rd;
        logic probe_next;
        logic ins_new;
        logic merge;
        logic set_cfull;
        logic set_tfull;
        logic set_empty;
        logic div_start;
        logic drain_done;
        logic out_load;
        logic clr_step;
    } cmd_t;

    typedef struct packed {
        logic drain_empty;
        logic drain_last;
        logic table_full;
        logic slot_vld;
        logic key_match;
        logic cnt_full;
        logic probe_last;
        logic div_done;
        logic out_free;
        logic clr_last;
        logic res_last;
    } sts_t;

endpackage

// File: hw/rtl/vgd_div.sv
// Four-lane restoring divider, one quotient bit per lane each cycle.
`timescale 1ns / 1ps

module vgd_div (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic [vgd_pkg::DIV_LANES-1:0][vgd_pkg::SUM_W-1:0] num,
    input  logic [vgd_pkg::DIV_LANES-1:0]               sgn,
    input  logic [vgd_pkg::CNT_W-1:0]                   den,
    output logic                                        done,
    output logic [vgd_pkg::DIV_LANES-1:0][vgd_pkg::COORD_W-1:0] quo
);

    logic [vgd_pkg::DIV_LANES-1:0][vgd_pkg::SUM_W-1:0] mag_reg;
    logic [vgd_pkg::DIV_LANES-1:0][vgd_pkg::SUM_W-1:0] mag_next;
    logic [vgd_pkg::DIV_LANES-1:0][vgd_pkg::CNT_W-1:0] rem_reg;
    logic [vgd_pkg::DIV_LANES-1:0][vgd_pkg::CNT_W-1:0] rem_next;
    logic [vgd_pkg::DIV_LANES-1:0]                     neg_reg;
    logic [vgd_pkg::CNT_W-1:0]                         den_reg;
    logic [vgd_pkg::DIV_CNT_W-1:0]                     cnt_reg;
    logic                                              busy_reg;
    logic                                              done_reg;
    logic [vgd_pkg::CNT_W:0]                           trial;

    always_comb
    begin
        mag_next = mag_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int l = 0; l < vgd_pkg::DIV_LANES; l++)
        begin
            trial = {rem_reg[l], mag_reg[l][vgd_pkg::SUM_W-1]};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next[l] = vgd_pkg::CNT_W'(trial - {1'b0, den_reg});
                mag_next[l] = {mag_reg[l][vgd_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[l] = trial[vgd_pkg::CNT_W-1:0];
                mag_next[l] = {mag_reg[l][vgd_pkg::SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == vgd_pkg::DIV_CNT_W'(vgd_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands are divided as magnitudes; the sign goes back on at the end,
    // which gives truncation toward zero.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            for (int l = 0; l < vgd_pkg::DIV_LANES; l++)
            begin
                neg_reg[l] <= sgn[l] & num[l][vgd_pkg::SUM_W-1];
                mag_reg[l] <= (sgn[l] & num[l][vgd_pkg::SUM_W-1]) ? (~num[l] + 1'b1) : num[l];
                rem_reg[l] <= '0;
            end
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    always_comb
    begin
        for (int l = 0; l < vgd_pkg::DIV_LANES; l++)
        begin
            quo[l] = neg_reg[l] ? (~mag_reg[l][vgd_pkg::COORD_W-1:0] + 1'b1)
                                : mag_reg[l][vgd_pkg::COORD_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

// File: hw/rtl/vgd_datapath.sv
// Datapath: key scaling, hashing, slot and entry memories, sums, divider and output register.
`timescale 1ns / 1ps

module vgd_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vgd_pkg::cmd_t                 cmd,
    output vgd_pkg::sts_t                 sts,
    input  logic [vgd_pkg::INV_W-1:0]     inv_voxel_size,
    input  logic [vgd_pkg::COORD_W-1:0]   in_x,
    input  logic [vgd_pkg::COORD_W-1:0]   in_y,
    input  logic [vgd_pkg::COORD_W-1:0]   in_z,
    input  logic [vgd_pkg::INT_W-1:0]     in_i,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [vgd_pkg::M_TDATA_W-1:0] out_data,
    output logic [2:0]                    out_status,
    output logic                          out_last
);

    localparam int EXT_W = vgd_pkg::SUM_W - vgd_pkg::COORD_W;

    vgd_pkg::slot_t  slot_mem [vgd_pkg::HASH_SLOTS];
    vgd_pkg::entry_t ent_mem  [vgd_pkg::CAPACITY];

    logic signed [vgd_pkg::COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [vgd_pkg::INT_W-1:0]          pi_reg;
    logic [vgd_pkg::KEY_W-1:0]          kx_reg, ky_reg, kz_reg;
    logic signed [vgd_pkg::PROD_W-1:0]  prod_x, prod_y, prod_z;
    logic signed [vgd_pkg::INV_W:0]     inv_s;
    logic [vgd_pkg::SLOT_W-1:0]         h1_reg;
    logic [vgd_pkg::SLOT_W-1:0]         probe_addr_reg;
    logic [vgd_pkg::PROBE_W-1:0]        probe_cnt_reg;
    vgd_pkg::slot_t                     slot_q;
    vgd_pkg::entry_t                    ent_q;
    logic [vgd_pkg::ENT_W-1:0]          ent_addr_reg;
    logic [vgd_pkg::ENT_W-1:0]          ent_raddr;
    logic [vgd_pkg::ENT_W-1:0]          ent_waddr;
    vgd_pkg::entry_t                    ent_wdata;
    logic                               ent_we;
    logic [vgd_pkg::SUM_W-1:0]          ext_x, ext_y, ext_z;
    logic [vgd_pkg::ENT_CNT_W-1:0]      entry_total_reg;
    logic [vgd_pkg::ENT_CNT_W-1:0]      drain_ptr_reg;
    logic [vgd_pkg::SLOT_W-1:0]         clr_cnt_reg;
    logic                               slot_we;
    logic [vgd_pkg::SLOT_W-1:0]         slot_waddr;
    vgd_pkg::slot_t                     slot_wdata;

    logic [2:0]                         res_status;
    logic [vgd_pkg::COORD_W-1:0]        res_x, res_y, res_z;
    logic [vgd_pkg::INT_W-1:0]          res_i;
    logic [vgd_pkg::CNT_W-1:0]          res_vp;
    logic                               res_last_reg;

    logic                               out_valid_reg;
    logic [vgd_pkg::M_TDATA_W-1:0]      out_data_reg;
    logic [2:0]                         out_status_reg;
    logic                               out_last_reg;

    logic [vgd_pkg::DIV_LANES-1:0][vgd_pkg::SUM_W-1:0]   div_num;
    logic [vgd_pkg::DIV_LANES-1:0][vgd_pkg::COORD_W-1:0] div_quo;
    logic                                                div_done;

    // Key = floor(coord * inv / 2^32): an arithmetic shift of the product floors.
    assign inv_s  = {1'b0, inv_voxel_size};
    assign prod_x = px_reg * inv_s;
    assign prod_y = py_reg * inv_s;
    assign prod_z = pz_reg * inv_s;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            px_reg <= in_x;
            py_reg <= in_y;
            pz_reg <= in_z;
            pi_reg <= in_i;
        end
        if (cmd.mul)
        begin
            kx_reg <= prod_x[vgd_pkg::FRAC_W +: vgd_pkg::KEY_W];
            ky_reg <= prod_y[vgd_pkg::FRAC_W +: vgd_pkg::KEY_W];
            kz_reg <= prod_z[vgd_pkg::FRAC_W +: vgd_pkg::KEY_W];
        end
        // Only the low slot-index bits of the 64-bit hash matter, and those
        // depend only on the low bits of each key.
        if (cmd.hash1)
        begin
            h1_reg <= kz_reg[vgd_pkg::SLOT_W-1:0] * vgd_pkg::HASH_MUL_LO
                      + ky_reg[vgd_pkg::SLOT_W-1:0];
        end
        if (cmd.hash2)
        begin
            probe_addr_reg <= h1_reg * vgd_pkg::HASH_MUL_LO + kx_reg[vgd_pkg::SLOT_W-1:0];
            probe_cnt_reg  <= '0;
        end
        else if (cmd.probe_next)
        begin
            probe_addr_reg <= probe_addr_reg + 1'b1;
            probe_cnt_reg  <= probe_cnt_reg + 1'b1;
        end
        if (cmd.ent_rd)
        begin
            ent_addr_reg <= slot_q.idx;
        end
    end

    // Slot memory: one write port shared by the clearing pass and inserts.
    always_comb
    begin
        slot_we    = cmd.clr_step | cmd.ins_new;
        slot_waddr = cmd.clr_step ? clr_cnt_reg : probe_addr_reg;
        slot_wdata = cmd.clr_step ? '0 : {1'b1, entry_total_reg[vgd_pkg::ENT_W-1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (cmd.slot_rd)
        begin
            slot_q <= slot_mem[probe_addr_reg];
        end
    end

    assign ext_x = {{EXT_W{px_reg[vgd_pkg::COORD_W-1]}}, px_reg};
    assign ext_y = {{EXT_W{py_reg[vgd_pkg::COORD_W-1]}}, py_reg};
    assign ext_z = {{EXT_W{pz_reg[vgd_pkg::COORD_W-1]}}, pz_reg};

    always_comb
    begin
        ent_raddr = cmd.drain_rd ? drain_ptr_reg[vgd_pkg::ENT_W-1:0] : slot_q.idx;
        ent_we    = cmd.ins_new | cmd.merge;
        ent_waddr = cmd.ins_new ? entry_total_reg[vgd_pkg::ENT_W-1:0] : ent_addr_reg;
        ent_wdata = ent_q;
        if (cmd.ins_new)
        begin
            ent_wdata.key_x = kx_reg;
            ent_wdata.key_y = ky_reg;
            ent_wdata.key_z = kz_reg;
            ent_wdata.sum_x = ext_x;
            ent_wdata.sum_y = ext_y;
            ent_wdata.sum_z = ext_z;
            ent_wdata.sum_i = vgd_pkg::ISUM_W'(pi_reg);
            ent_wdata.cnt   = vgd_pkg::CNT_W'(1);
        end
        else
        begin
            ent_wdata.sum_x = ent_q.sum_x + ext_x;
            ent_wdata.sum_y = ent_q.sum_y + ext_y;
            ent_wdata.sum_z = ent_q.sum_z + ext_z;
            ent_wdata.sum_i = ent_q.sum_i + vgd_pkg::ISUM_W'(pi_reg);
            ent_wdata.cnt   = ent_q.cnt + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (cmd.drain_rd || cmd.ent_rd)
        begin
            ent_q <= ent_mem[ent_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_total_reg <= '0;
            drain_ptr_reg   <= '0;
            clr_cnt_reg     <= '0;
            res_last_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.ins_new)
            begin
                entry_total_reg <= entry_total_reg + 1'b1;
            end
            if (cmd.drain_done)
            begin
                res_last_reg <= sts.drain_last;
                if (sts.drain_last)
                begin
                    entry_total_reg <= '0;
                    drain_ptr_reg   <= '0;
                end
                else
                begin
                    drain_ptr_reg <= drain_ptr_reg + 1'b1;
                end
            end
            else if (cmd.ins_new || cmd.merge || cmd.set_cfull || cmd.set_tfull
                     || cmd.set_empty)
            begin
                res_last_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_new || cmd.merge || cmd.set_cfull || cmd.set_tfull || cmd.set_empty)
        begin
            res_x <= '0;
            res_y <= '0;
            res_z <= '0;
            res_i <= '0;
        end
        if (cmd.ins_new)
        begin
            res_status <= vgd_pkg::ST_NEW;
            res_vp     <= vgd_pkg::CNT_W'(1);
        end
        if (cmd.merge)
        begin
            res_status <= vgd_pkg::ST_MERGED;
            res_vp     <= ent_q.cnt + 1'b1;
        end
        if (cmd.set_cfull)
        begin
            res_status <= vgd_pkg::ST_CFULL;
            res_vp     <= ent_q.cnt;
        end
        if (cmd.set_tfull)
        begin
            res_status <= vgd_pkg::ST_TFULL;
            res_vp     <= '0;
        end
        if (cmd.set_empty)
        begin
            res_status <= vgd_pkg::ST_EMPTY;
            res_vp     <= '0;
        end
        if (cmd.drain_done)
        begin
            res_status <= vgd_pkg::ST_DRAINED;
            res_x      <= div_quo[0];
            res_y      <= div_quo[1];
            res_z      <= div_quo[2];
            res_i      <= div_quo[3][vgd_pkg::INT_W-1:0];
            res_vp     <= ent_q.cnt;
        end
    end

    assign div_num[0] = ent_q.sum_x;
    assign div_num[1] = ent_q.sum_y;
    assign div_num[2] = ent_q.sum_z;
    assign div_num[3] = vgd_pkg::SUM_W'(ent_q.sum_i);

    vgd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .sgn   (4'b0111),
        .den   (ent_q.cnt),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg   <= {res_vp, res_i, res_z, res_y, res_x};
            out_status_reg <= res_status;
            out_last_reg   <= res_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    always_comb
    begin
        sts.drain_empty = drain_ptr_reg >= entry_total_reg;
        sts.drain_last  = (drain_ptr_reg + 1'b1) == entry_total_reg;
        sts.table_full  = entry_total_reg >= vgd_pkg::ENT_CNT_W'(vgd_pkg::CAPACITY);
        sts.slot_vld    = slot_q.vld;
        sts.key_match   = (ent_q.key_x == kx_reg) && (ent_q.key_y == ky_reg)
                          && (ent_q.key_z == kz_reg);
        sts.cnt_full    = ent_q.cnt == vgd_pkg::COUNT_MAX;
        sts.probe_last  = probe_cnt_reg == vgd_pkg::PROBE_W'(vgd_pkg::MAX_PROBE - 1);
        sts.div_done    = div_done;
        sts.out_free    = !out_valid_reg || out_ready;
        sts.clr_last    = clr_cnt_reg == vgd_pkg::SLOT_W'(vgd_pkg::HASH_SLOTS - 1);
        sts.res_last    = res_last_reg;
    end

endmodule

// File: hw/rtl/vgd_ctrl.sv
// Controller state machine sequencing adds, drains and the slot clearing pass.
`timescale 1ns / 1ps

module vgd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_func,
    output logic          in_ready,
    input  vgd_pkg::sts_t sts,
    output vgd_pkg::cmd_t cmd
);

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_MUL      = 11'b000_0000_0100,
        S_HASH1    = 11'b000_0000_1000,
        S_HASH2    = 11'b000_0001_0000,
        S_SLOT_RD  = 11'b000_0010_0000,
        S_SLOT_CHK = 11'b000_0100_0000,
        S_ENT_CHK  = 11'b000_1000_0000,
        S_DIV_GO   = 11'b001_0000_0000,
        S_DIV      = 11'b010_0000_0000,
        S_OUT      = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_func == vgd_pkg::FN_ADD)
                    begin
                        state_next = S_MUL;
                    end
                    else if (sts.drain_empty)
                    begin
                        cmd.set_empty = 1'b1;
                        state_next    = S_OUT;
                    end
                    else
                    begin
                        cmd.drain_rd = 1'b1;
                        state_next   = S_DIV_GO;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_HASH1;
            end
            S_HASH1:
            begin
                cmd.hash1  = 1'b1;
                state_next = S_HASH2;
            end
            S_HASH2:
            begin
                cmd.hash2  = 1'b1;
                state_next = S_SLOT_RD;
            end
            S_SLOT_RD:
            begin
                cmd.slot_rd = 1'b1;
                state_next  = S_SLOT_CHK;
            end
            S_SLOT_CHK:
            begin
                if (!sts.slot_vld)
                begin
                    if (sts.table_full)
                    begin
                        cmd.set_tfull = 1'b1;
                    end
                    else
                    begin
                        cmd.ins_new = 1'b1;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = S_ENT_CHK;
                end
            end
            S_ENT_CHK:
            begin
                if (sts.key_match)
                begin
                    if (sts.cnt_full)
                    begin
                        cmd.set_cfull = 1'b1;
                    end
                    else
                    begin
                        cmd.merge = 1'b1;
                    end
                    state_next = S_OUT;
                end
                else if (sts.probe_last)
                begin
                    cmd.set_tfull = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_SLOT_RD;
                end
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.drain_done = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sts.res_last ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// File: hw/rtl/voxel_grid_downsampler.sv
// Voxel grid downsampler: hashes points into voxels and drains their centroids.
// One item is handled at a time. An add steps through the key multiply, two hash steps
// and a slot read, then creates a voxel there or reads its entry to merge; each further
// slot probed adds a slot read, entry read and key compare, up to MAX_PROBE slots.
// A drain that finds a voxel is paced by the bit-serial divider that produces the four
// averages together, one quotient bit per cycle over 56 bits; a drain with nothing left
// skips the divider. After reset and after the final voxel is drained the slot table is
// swept, one slot per cycle over all HASH_SLOTS (8192) slots, during which no item is
// accepted; register writes are taken at any time. A finished result waits in an output
// register while the next item is accepted.
`timescale 1ns / 1ps

module voxel_grid_downsampler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // point_x, point_y, point_z, point_intensity
    input  logic [vgd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_x, out_y, out_z, out_intensity, voxel_points
    output logic [vgd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [2:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);

    localparam int CW = vgd_pkg::COORD_W;

    logic [vgd_pkg::INV_W-1:0] inv_reg;
    vgd_pkg::cmd_t             cmd;
    vgd_pkg::sts_t             sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= vgd_pkg::INV_RESET;
        end
        else if (psel && penable && pwrite && pready && !paddr[2])
        begin
            inv_reg <= pwdata[vgd_pkg::INV_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32 - vgd_pkg::INV_W){1'b0}}, inv_reg};

    vgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_func  (s_axis_tuser[0]),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vgd_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .inv_voxel_size (inv_reg),
        .in_x           (s_axis_tdata[CW-1:0]),
        .in_y           (s_axis_tdata[2*CW-1:CW]),
        .in_z           (s_axis_tdata[3*CW-1:2*CW]),
        .in_i           (s_axis_tdata[3*CW +: vgd_pkg::INT_W]),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_data       (m_axis_tdata),
        .out_status     (m_axis_tuser),
        .out_last       (m_axis_tlast)
    );

endmodule

// File: hw/rtl/vgd_checker.sv
// Port-level checks of the voxel grid downsampler, bound to the top level.
`timescale 1ns / 1ps

module vgd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [vgd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [2:0]                    m_axis_tuser,
    input logic                          m_axis_tlast
);

    localparam int VP_LO = 3 * vgd_pkg::COORD_W + vgd_pkg::INT_W;

    // A stalled result transfer keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Only a drain that returns a voxel can mark the end of the stored set.
    a_last_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == vgd_pkg::ST_DRAINED)
        else $error("last flag on a result that is not a drained voxel");

    // A newly created voxel always holds exactly one point.
    a_new_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == vgd_pkg::ST_NEW
        |-> m_axis_tdata[VP_LO +: vgd_pkg::CNT_W] == vgd_pkg::CNT_W'(1))
        else $error("new voxel with a count other than one");

    // Table-full drops and empty results carry no point count and no average.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == vgd_pkg::ST_EMPTY
        || m_axis_tuser == vgd_pkg::ST_TFULL) |-> m_axis_tdata == '0)
        else $error("empty or table-full result with nonzero fields");

endmodule

bind voxel_grid_downsampler vgd_checker u_vgd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: bench/voxel_grid_downsampler_tb.sv
// Self-checking testbench of the voxel grid downsampler with its own voxel table predictor.
`timescale 1ns / 1ps

module voxel_grid_downsampler_tb;

    localparam logic [2:0] REG_INV_VOXEL_SIZE = 3'd0;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 100;
    localparam int WATCHDOG_LIMIT = 30000;

    typedef enum int {
        GAP_NONE   = 0,
        GAP_SENDER = 1,
        GAP_RECV   = 2,
        GAP_BOTH   = 3
    } gap_mode_t;

    typedef struct {
        vgd_pkg::func_t fn;
        logic [31:0]    px;
        logic [31:0]    py;
        logic [31:0]    pz;
        logic [15:0]    pi;
    } point_item_t;

    typedef struct {
        vgd_pkg::status_t st;
        logic [31:0]      ax;
        logic [31:0]      ay;
        logic [31:0]      az;
        logic [15:0]      ai;
        logic [23:0]      pts;
        logic             fin;
    } voxel_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // point_x, point_y, point_z, point_intensity
    logic [vgd_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    // func
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // out_x, out_y, out_z, out_intensity, voxel_points
    logic [vgd_pkg::M_TDATA_W-1:0] m_axis_tdata;
    // status
    logic [2:0] m_axis_tuser;
    logic m_axis_tlast;

    voxel_grid_downsampler uut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    point_item_t pending_points[$];
    voxel_result_t expected_voxels[$];
    gap_mode_t gap_mode = GAP_NONE;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int points_added = 0;
    int voxels_drained = 0;
    int drops_seen = 0;

    // Predictor copy of the voxel table.
    logic [23:0] inv_scale = vgd_pkg::INV_RESET;
    bit slot_used[vgd_pkg::HASH_SLOTS];
    int slot_entry[vgd_pkg::HASH_SLOTS];
    longint vox_kx[vgd_pkg::CAPACITY], vox_ky[vgd_pkg::CAPACITY], vox_kz[vgd_pkg::CAPACITY];
    longint vox_sx[vgd_pkg::CAPACITY], vox_sy[vgd_pkg::CAPACITY], vox_sz[vgd_pkg::CAPACITY];
    longint vox_si[vgd_pkg::CAPACITY];
    longint vox_cnt[vgd_pkg::CAPACITY];
    int voxel_total = 0;
    int drain_next = 0;

    function automatic longint floor_key(input logic [31:0] c);
        return (longint'(signed'(c)) * longint'(inv_scale)) >>> 32;
    endfunction

    task automatic predict_voxel(input point_item_t it);
        longint kx, ky, kz, c;
        logic [63:0] h;
        int s, t, e, k, empty_slot;
        bit found, have_empty;
        voxel_result_t r;
        begin
            r = '{st: vgd_pkg::ST_MERGED, ax: 0, ay: 0, az: 0, ai: 0, pts: 0, fin: 0};
            found = 0;
            have_empty = 0;
            e = 0;
            empty_slot = 0;
            if (it.fn == vgd_pkg::FN_ADD)
            begin
                kx = floor_key(it.px);
                ky = floor_key(it.py);
                kz = floor_key(it.pz);
                h = kz;
                h = h * 64'(vgd_pkg::HASH_MUL) + 64'(ky);
                h = h * 64'(vgd_pkg::HASH_MUL) + 64'(kx);
                s = int'(h % 64'(vgd_pkg::HASH_SLOTS));
                for (k = 0; k < vgd_pkg::MAX_PROBE; k++)
                begin
                    t = (s + k) % vgd_pkg::HASH_SLOTS;
                    if (!slot_used[t])
                    begin
                        have_empty = 1;
                        empty_slot = t;
                        break;
                    end
                    e = slot_entry[t];
                    if (vox_kx[e] == kx && vox_ky[e] == ky && vox_kz[e] == kz)
                    begin
                        found = 1;
                        break;
                    end
                end
                if (found)
                begin
                    if (vox_cnt[e] >= longint'(vgd_pkg::COUNT_MAX))
                        r.st = vgd_pkg::ST_CFULL;
                    else
                    begin
                        vox_sx[e] += longint'(signed'(it.px));
                        vox_sy[e] += longint'(signed'(it.py));
                        vox_sz[e] += longint'(signed'(it.pz));
                        vox_si[e] += longint'(it.pi);
                        vox_cnt[e]++;
                        r.st = vgd_pkg::ST_MERGED;
                    end
                    r.pts = 24'(vox_cnt[e]);
                end
                else if (!have_empty || voxel_total >= vgd_pkg::CAPACITY)
                    r.st = vgd_pkg::ST_TFULL;
                else
                begin
                    e = voxel_total;
                    slot_used[empty_slot] = 1;
                    slot_entry[empty_slot] = e;
                    vox_kx[e] = kx;
                    vox_ky[e] = ky;
                    vox_kz[e] = kz;
                    vox_sx[e] = longint'(signed'(it.px));
                    vox_sy[e] = longint'(signed'(it.py));
                    vox_sz[e] = longint'(signed'(it.pz));
                    vox_si[e] = longint'(it.pi);
                    vox_cnt[e] = 1;
                    voxel_total++;
                    r.st = vgd_pkg::ST_NEW;
                    r.pts = 24'd1;
                end
            end
            else if (drain_next >= voxel_total)
                r.st = vgd_pkg::ST_EMPTY;
            else
            begin
                e = drain_next;
                c = (vox_cnt[e] < 1) ? 1 : vox_cnt[e];
                r.st = vgd_pkg::ST_DRAINED;
                r.ax = 32'(vox_sx[e] / c);
                r.ay = 32'(vox_sy[e] / c);
                r.az = 32'(vox_sz[e] / c);
                r.ai = 16'(vox_si[e] / c);
                r.pts = 24'(vox_cnt[e]);
                drain_next++;
                if (drain_next == voxel_total)
                begin
                    r.fin = 1'b1;
                    for (k = 0; k < vgd_pkg::HASH_SLOTS; k++)
                        slot_used[k] = 0;
                    voxel_total = 0;
                    drain_next = 0;
                end
            end
            expected_voxels = {expected_voxels, r};
        end
    endtask

    // Sender: a new item is offered only once the previous one has been taken.
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_points.size() > 0 &&
                !((gap_mode == GAP_SENDER && $urandom_range(0, 99) < 67) ||
                  (gap_mode == GAP_BOTH && $urandom_range(0, 99) < 27)))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= pending_points[0].fn;
                s_axis_tdata <= {pending_points[0].pi, pending_points[0].pz,
                                 pending_points[0].py, pending_points[0].px};
                void'(pending_points.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (gap_mode == GAP_RECV)
            m_axis_tready <= ($urandom_range(0, 99) >= 67);
        else if (gap_mode == GAP_BOTH)
            m_axis_tready <= ($urandom_range(0, 99) >= 27);
        else
            m_axis_tready <= 1'b1;
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge clk)
    begin
        point_item_t it;
        voxel_result_t want;
        voxel_result_t got;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            it.fn = vgd_pkg::func_t'(s_axis_tuser[0]);
            it.px = s_axis_tdata[31:0];
            it.py = s_axis_tdata[63:32];
            it.pz = s_axis_tdata[95:64];
            it.pi = s_axis_tdata[111:96];
            predict_voxel(it);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.st = vgd_pkg::status_t'(m_axis_tuser);
            got.ax = m_axis_tdata[31:0];
            got.ay = m_axis_tdata[63:32];
            got.az = m_axis_tdata[95:64];
            got.ai = m_axis_tdata[111:96];
            got.pts = m_axis_tdata[135:112];
            got.fin = m_axis_tlast;
            if (got.st == vgd_pkg::ST_NEW || got.st == vgd_pkg::ST_MERGED)
                points_added++;
            else if (got.st == vgd_pkg::ST_DRAINED)
                voxels_drained++;
            else if (got.st == vgd_pkg::ST_TFULL || got.st == vgd_pkg::ST_CFULL)
                drops_seen++;
            if (expected_voxels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d pts %0d", got.st, got.pts);
            end
            else
            begin
                want = expected_voxels.pop_front();
                if (got.st !== want.st || got.ax !== want.ax || got.ay !== want.ay ||
                    got.az !== want.az || got.ai !== want.ai || got.pts !== want.pts ||
                    got.fin !== want.fin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp: st %0d x %h y %h z %h i %h pts %0d last %b",
                                 want.st, want.ax, want.ay, want.az, want.ai, want.pts,
                                 want.fin);
                        $display("         got: st %0d x %h y %h z %h i %h pts %0d last %b",
                                 got.st, got.ax, got.ay, got.az, got.ai, got.pts, got.fin);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_inv_voxel_size(input logic [23:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_INV_VOXEL_SIZE;
        pwdata <= {8'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        inv_scale = value;
    endtask

    task automatic wait_quiet();
        while (pending_points.size() != 0 || s_axis_tvalid || expected_voxels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_point(input vgd_pkg::func_t fn, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z,
                              input logic [15:0] i);
        point_item_t it;
        it = '{fn: fn, px: x, py: y, pz: z, pi: i};
        pending_points = {pending_points, it};
    endtask

    function automatic logic [31:0] pick_coord();
        // Mostly points near the origin so that voxels collect several points.
        if ($urandom_range(0, 3) != 0)
            return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
        return $urandom;
    endfunction

    task automatic push_random(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 4) == 0)
                push_point(vgd_pkg::FN_DRAIN, $urandom, $urandom, $urandom, 16'($urandom));
            else
                push_point(vgd_pkg::FN_ADD, pick_coord(), pick_coord(), pick_coord(),
                           16'($urandom));
        end
    endtask

    // Drains whatever voxels are left so that the table is cleared.
    task automatic drain_all();
        int n;
        wait_quiet();
        for (n = 0; n <= voxel_total - drain_next; n++)
            push_point(vgd_pkg::FN_DRAIN, '0, '0, '0, '0);
        wait_quiet();
    endtask

    initial
    begin
        logic [23:0] phase_inv[6];
        int p, n;
        phase_inv = '{24'hFFFFFF, 24'd0, 24'd1, 24'd65536, 24'($urandom), 24'($urandom)};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        write_inv_voxel_size(24'd65536);

        push_point(vgd_pkg::FN_DRAIN, '0, '0, '0, '0);
        push_point(vgd_pkg::FN_ADD, '0, '0, '0, '0);
        push_point(vgd_pkg::FN_ADD, 32'hFFFF, 32'hFFFF, 32'hFFFF, 16'hFFFF);
        // Just below zero must floor to key -1, not truncate to 0.
        push_point(vgd_pkg::FN_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'h0);
        push_point(vgd_pkg::FN_ADD, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF);
        push_point(vgd_pkg::FN_ADD, 32'h80000000, 32'h80000000, 32'h80000000, 16'h0);
        // Keys that are multiples of the slot count share the first probed slot.
        for (n = -4; n <= 3; n++)
            if (n != 0)
                push_point(vgd_pkg::FN_ADD, 32'(n) << 29, '0, '0, 16'h1234);
        push_point(vgd_pkg::FN_ADD, '0, 32'h20000000, '0, 16'h5678);
        push_point(vgd_pkg::FN_ADD, '0, 32'h20000000, '0, 16'h5678);
        for (n = 0; n < 11; n++)
            push_point(vgd_pkg::FN_DRAIN, '0, '0, '0, '0);
        drain_all();

        for (p = 0; p < 6; p++)
        begin
            gap_mode = gap_mode_t'(p % 4);
            write_inv_voxel_size(phase_inv[p]);
            push_random(60);
            drain_all();
        end

        // The receiver holds off while the sender keeps offering items.
        gap_mode = GAP_NONE;
        write_inv_voxel_size(24'd65536);
        hold_req <= ~hold_req;
        push_random(30);
        drain_all();

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered adds, merges, drains, empty drains and table-full drops;");
        $display("%0d points stored, %0d voxels drained, %0d dropped, over 8 scale settings",
                 points_added, voxels_drained, drops_seen);
        if (mismatches == 0)
            $display("TB_OK");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/vgd_pkg.sv
hw/rtl/vgd_div.sv
hw/rtl/vgd_datapath.sv
hw/rtl/vgd_ctrl.sv
hw/rtl/voxel_grid_downsampler.sv
hw/rtl/vgd_checker.sv
bench/voxel_grid_downsampler_tb.sv
